@@ src/bpts_pkg.sv @@
`timescale 1ns / 1ps

package bpts_pkg;

	localparam int unsigned SEQ_LEN   = 4;
	localparam int unsigned SEQ_SLOTS = 4;
	localparam int unsigned IDX_W     = 2;

	localparam int unsigned DEB_W  = 10;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned HZ_W   = 15;
	localparam int unsigned MS_W   = 8;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [HZ_W-1:0] FB_ON_HZ  = HZ_W'(1000);
	localparam logic [HZ_W-1:0] FB_OFF_HZ = HZ_W'(600);
	localparam logic [MS_W-1:0] FB_MS     = MS_W'(120);
	localparam logic [MS_W-1:0] SEQ_MS    = MS_W'(180);

	localparam logic [DEB_W-1:0] DEB_RST      = DEB_W'(50);
	localparam logic [CNT_W-1:0] LONG_RST     = CNT_W'(500);
	localparam logic [CNT_W-1:0] INTERVAL_RST = CNT_W'(300);
	localparam logic [HZ_W-1:0]  FREQ0_RST    = HZ_W'(440);
	localparam logic [HZ_W-1:0]  FREQ1_RST    = HZ_W'(660);
	localparam logic [HZ_W-1:0]  FREQ2_RST    = HZ_W'(550);
	localparam logic [HZ_W-1:0]  FREQ3_RST    = HZ_W'(880);

	// register indexes
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_LONG     = 3'd1;
	localparam logic [2:0] REG_INTERVAL = 3'd2;
	localparam logic [2:0] REG_FREQ0    = 3'd3;
	localparam logic [2:0] REG_FREQ1    = 3'd4;
	localparam logic [2:0] REG_FREQ2    = 3'd5;
	localparam logic [2:0] REG_FREQ3    = 3'd6;

	// request kinds
	localparam logic [1:0] KIND_SEQ    = 2'd0;
	localparam logic [1:0] KIND_FB_ON  = 2'd1;
	localparam logic [1:0] KIND_FB_OFF = 2'd2;

	typedef struct packed {
		logic [DEB_W-1:0]                debounce;
		logic [CNT_W-1:0]                long_press;
		logic [CNT_W-1:0]                interval;
		logic [SEQ_SLOTS-1:0][HZ_W-1:0] freq;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
		logic             led;
		logic             last;
	} req_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] n;
		n = {1'b0, i} + (IDX_W+1)'(1);
		next_idx = (n >= (IDX_W+1)'(SEQ_LEN)) ? '0 : n[IDX_W-1:0];
	endfunction

endpackage

@@ src/bpts_regs.sv @@
`timescale 1ns / 1ps

module bpts_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpts_pkg::ADDR_W-1:0] paddr,
	input  logic [bpts_pkg::DATA_W-1:0] pwdata,
	output logic [bpts_pkg::DATA_W-1:0] prdata,
	output bpts_pkg::cfg_t              cfg
);
	import bpts_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce   <= DEB_RST;
			cfg_q.long_press <= LONG_RST;
			cfg_q.interval   <= INTERVAL_RST;
			cfg_q.freq[0]    <= FREQ0_RST;
			cfg_q.freq[1]    <= FREQ1_RST;
			cfg_q.freq[2]    <= FREQ2_RST;
			cfg_q.freq[3]    <= FREQ3_RST;
		end else if (wr) begin
			case (idx)
				REG_DEBOUNCE: cfg_q.debounce   <= pwdata[DEB_W-1:0];
				REG_LONG:     cfg_q.long_press <= pwdata[CNT_W-1:0];
				REG_INTERVAL: cfg_q.interval   <= pwdata[CNT_W-1:0];
				REG_FREQ0:    cfg_q.freq[0]    <= pwdata[HZ_W-1:0];
				REG_FREQ1:    cfg_q.freq[1]    <= pwdata[HZ_W-1:0];
				REG_FREQ2:    cfg_q.freq[2]    <= pwdata[HZ_W-1:0];
				REG_FREQ3:    cfg_q.freq[3]    <= pwdata[HZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_DEBOUNCE: prdata = DATA_W'(cfg_q.debounce);
			REG_LONG:     prdata = DATA_W'(cfg_q.long_press);
			REG_INTERVAL: prdata = DATA_W'(cfg_q.interval);
			REG_FREQ0:    prdata = DATA_W'(cfg_q.freq[0]);
			REG_FREQ1:    prdata = DATA_W'(cfg_q.freq[1]);
			REG_FREQ2:    prdata = DATA_W'(cfg_q.freq[2]);
			REG_FREQ3:    prdata = DATA_W'(cfg_q.freq[3]);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ src/bpts_front.sv @@
`timescale 1ns / 1ps

module bpts_front (
	input  logic           clk,
	input  logic           arst_n,
	input  bpts_pkg::cfg_t cfg,
	input  logic           accept,
	input  logic           raw_level,
	output logic [1:0]     push_cnt,
	output bpts_pkg::req_t req0,
	output bpts_pkg::req_t req1
);
	import bpts_pkg::*;

	logic             prev_q, stable_q, auto_q;
	logic [CNT_W-1:0] since_change_q, press_q, since_auto_q;
	logic [IDX_W-1:0] seq_q;

	logic [CNT_W-1:0] since_change_n, press_n, since_auto_n, press_inc, auto_inc;
	logic             deb, press_res, auto_res, auto_n, long_press;
	logic [IDX_W-1:0] seq_mid, seq_n;
	req_t             press_req, auto_req;

	always_comb begin
		since_change_n = (raw_level != prev_q) ? '0 : sat_inc(since_change_q);
		press_inc      = sat_inc(press_q);
		auto_inc       = sat_inc(since_auto_q);
		deb = (since_change_n > CNT_W'(cfg.debounce)) && (stable_q != raw_level);
		long_press = press_inc >= cfg.long_press;

		press_n   = press_inc;
		auto_n    = auto_q;
		seq_mid   = seq_q;
		press_res = 1'b0;
		press_req = '0;

		if (deb) begin
			if (!raw_level) begin
				press_n = '0;
			end else if (long_press) begin
				auto_n         = ~auto_q;
				press_res      = 1'b1;
				press_req.kind = auto_n ? KIND_FB_ON : KIND_FB_OFF;
				press_req.led  = auto_n;
			end else begin
				press_res      = 1'b1;
				press_req.kind = KIND_SEQ;
				press_req.idx  = seq_q;
				press_req.led  = auto_q;
				seq_mid        = next_idx(seq_q);
			end
		end

		auto_res      = auto_n && (auto_inc >= cfg.interval);
		since_auto_n  = auto_res ? '0 : auto_inc;
		seq_n         = auto_res ? next_idx(seq_mid) : seq_mid;
		auto_req.kind = KIND_SEQ;
		auto_req.idx  = seq_mid;
		auto_req.led  = auto_n;
		auto_req.last = 1'b1;

		press_req.last = !auto_res;
		req0     = press_res ? press_req : auto_req;
		req1     = auto_req;
		push_cnt = {1'b0, press_res} + {1'b0, auto_res};
		if (!accept) begin
			push_cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q         <= 1'b1;
			stable_q       <= 1'b1;
			auto_q         <= 1'b0;
			since_change_q <= '0;
			press_q        <= '0;
			since_auto_q   <= '0;
			seq_q          <= '0;
		end else if (accept) begin
			prev_q         <= raw_level;
			if (deb) begin
				stable_q <= raw_level;
			end
			auto_q         <= auto_n;
			since_change_q <= since_change_n;
			press_q        <= press_n;
			since_auto_q   <= since_auto_n;
			seq_q          <= seq_n;
		end
	end

endmodule

@@ src/bpts_queue.sv @@
`timescale 1ns / 1ps

module bpts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_cnt,
	input  bpts_pkg::req_t req0,
	input  bpts_pkg::req_t req1,
	output logic           room2,
	output logic           head_valid,
	output bpts_pkg::req_t head,
	input  logic           pop
);
	import bpts_pkg::*;

	req_t           mem [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   count_q;
	logic [QAW-1:0] wr_p1;

	assign wr_p1      = wr_q + QAW'(1);
	assign room2      = count_q <= (QAW+1)'(QDEPTH - 2);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_q] <= req0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_p1] <= req1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(push_cnt);
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			count_q <= count_q + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
		end
	end

endmodule

@@ src/bpts_back.sv @@
`timescale 1ns / 1ps

module bpts_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpts_pkg::cfg_t            cfg,
	input  logic                      head_valid,
	input  bpts_pkg::req_t            head,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [bpts_pkg::HZ_W-1:0] tone_hz,
	output logic [bpts_pkg::MS_W-1:0] tone_ms,
	output logic                      led_on,
	output logic                      last_of_tick
);
	import bpts_pkg::*;

	logic            valid_q, led_q, last_q;
	logic [HZ_W-1:0] hz_q, hz_n;
	logic [MS_W-1:0] ms_q, ms_n;

	assign pop = head_valid && (!valid_q || !out_stall);

	always_comb begin
		case (head.kind)
			KIND_SEQ: begin
				hz_n = cfg.freq[head.idx];
				ms_n = SEQ_MS;
			end
			KIND_FB_ON: begin
				hz_n = FB_ON_HZ;
				ms_n = FB_MS;
			end
			KIND_FB_OFF: begin
				hz_n = FB_OFF_HZ;
				ms_n = FB_MS;
			end
			default: begin
				hz_n = '0;
				ms_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hz_q   <= hz_n;
			ms_q   <= ms_n;
			led_q  <= head.led;
			last_q <= head.last;
		end
	end

	assign out_valid    = valid_q;
	assign tone_hz      = hz_q;
	assign tone_ms      = ms_q;
	assign led_on       = led_q;
	assign last_of_tick = last_q;

endmodule

@@ src/button_press_tone_sequencer_unit.sv @@
`timescale 1ns / 1ps

// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, raw_level             | request in
// out     | out_valid, out_stall, tone_hz, tone_ms,   | request out
//         | led_on, last_of_tick                      |
// cfg     | psel, penable, pwrite, paddr, pwdata,     | APB write/read
//         | prdata, pready                            |
// Unless stalled, one tick is taken per cycle; the front updates every counter.
// Results pass a four-entry queue and leave through a registered output stage,
// one per cycle unless out_stall holds them; each is queued, then registered.
// in_stall rises when the queue has room for fewer than two requests.
// Reset clears counters, pointers and valid flag, and loads register defaults.

module button_press_tone_sequencer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        raw_level,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpts_pkg::HZ_W-1:0]   tone_hz,
	output logic [bpts_pkg::MS_W-1:0]   tone_ms,
	output logic                        led_on,
	output logic                        last_of_tick,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpts_pkg::ADDR_W-1:0] paddr,
	input  logic [bpts_pkg::DATA_W-1:0] pwdata,
	output logic [bpts_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import bpts_pkg::*;

	cfg_t       cfg;
	req_t       req0, req1, head;
	logic [1:0] push_cnt;
	logic       room2, head_valid, pop, accept;

	assign pready   = 1'b1;
	assign in_stall = !room2;
	assign accept   = in_valid && room2;

	bpts_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	bpts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.raw_level(raw_level),
		.push_cnt (push_cnt),
		.req0     (req0),
		.req1     (req1)
	);

	bpts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.req0      (req0),
		.req1      (req1),
		.room2     (room2),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop)
	);

	bpts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tone_hz     (tone_hz),
		.tone_ms     (tone_ms),
		.led_on      (led_on),
		.last_of_tick(last_of_tick)
	);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import bpts_pkg::*;

	localparam int         NREGS    = 7;
	localparam logic [2:0] REG_NONE = 3'd7;

	typedef struct {
		logic [HZ_W-1:0] hz;
		logic [MS_W-1:0] ms;
		logic            led;
		logic            last;
	} tone_t;

	class tone_scoreboard;
		logic [DEB_W-1:0] debounce;
		logic [CNT_W-1:0] long_press;
		logic [CNT_W-1:0] interval;
		logic [HZ_W-1:0]  freq [SEQ_SLOTS];
		logic             prev_raw;
		logic [CNT_W-1:0] since_change;
		logic             stable;
		logic [CNT_W-1:0] press_ticks;
		logic [IDX_W-1:0] seq_idx;
		logic             auto_on;
		logic [CNT_W-1:0] since_auto;
		tone_t            pending[$];
		int               errors;
		int               ticks;
		int               tones;

		function new();
			debounce     = DEB_RST;
			long_press   = LONG_RST;
			interval     = INTERVAL_RST;
			freq[0]      = FREQ0_RST;
			freq[1]      = FREQ1_RST;
			freq[2]      = FREQ2_RST;
			freq[3]      = FREQ3_RST;
			prev_raw     = 1'b1;
			since_change = '0;
			stable       = 1'b1;
			press_ticks  = '0;
			seq_idx      = '0;
			auto_on      = 1'b0;
			since_auto   = '0;
			errors       = 0;
			ticks        = 0;
			tones        = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t ERROR %s", $time, msg);
		endfunction

		function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_DEBOUNCE: debounce = val[DEB_W-1:0];
				REG_LONG:     long_press = val[CNT_W-1:0];
				REG_INTERVAL: interval = val[CNT_W-1:0];
				REG_FREQ0:    freq[0] = val[HZ_W-1:0];
				REG_FREQ1:    freq[1] = val[HZ_W-1:0];
				REG_FREQ2:    freq[2] = val[HZ_W-1:0];
				REG_FREQ3:    freq[3] = val[HZ_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_DEBOUNCE: return DATA_W'(debounce);
				REG_LONG:     return DATA_W'(long_press);
				REG_INTERVAL: return DATA_W'(interval);
				REG_FREQ0:    return DATA_W'(freq[0]);
				REG_FREQ1:    return DATA_W'(freq[1]);
				REG_FREQ2:    return DATA_W'(freq[2]);
				REG_FREQ3:    return DATA_W'(freq[3]);
				default:      return '0;
			endcase
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function logic [HZ_W-1:0] take_seq_tone();
			logic [HZ_W-1:0] hz;
			hz = freq[seq_idx];
			seq_idx = (int'(seq_idx) + 1 >= int'(SEQ_LEN)) ? '0 : seq_idx + 1'b1;
			return hz;
		endfunction

		// one accepted tick: update the debouncer and queue the tones it causes
		function void note_tick(logic lvl);
			tone_t made[$];
			tone_t t;
			ticks++;
			if (lvl != prev_raw) begin
				since_change = '0;
				prev_raw = lvl;
			end else begin
				since_change = bump(since_change);
			end
			press_ticks = bump(press_ticks);
			since_auto = bump(since_auto);
			if (since_change > CNT_W'(debounce) && stable != lvl) begin
				stable = lvl;
				if (!lvl) begin
					press_ticks = '0;
				end else if (press_ticks >= long_press) begin
					auto_on = ~auto_on;
					t.hz = auto_on ? FB_ON_HZ : FB_OFF_HZ;
					t.ms = FB_MS;
					t.led = auto_on;
					t.last = 1'b0;
					made.push_back(t);
				end else begin
					t.hz = take_seq_tone();
					t.ms = SEQ_MS;
					t.led = auto_on;
					t.last = 1'b0;
					made.push_back(t);
				end
			end
			if (auto_on && since_auto >= interval) begin
				since_auto = '0;
				t.hz = take_seq_tone();
				t.ms = SEQ_MS;
				t.led = auto_on;
				t.last = 1'b0;
				made.push_back(t);
			end
			if (made.size() > 0)
				made[made.size()-1].last = 1'b1;
			foreach (made[i])
				pending.push_back(made[i]);
		endfunction

		function void check_tone(tone_t got);
			tone_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected tone hz=%0d ms=%0d led=%b last=%b",
					got.hz, got.ms, got.led, got.last));
				return;
			end
			want = pending.pop_front();
			tones++;
			if (got.hz !== want.hz || got.ms !== want.ms || got.led !== want.led ||
					got.last !== want.last)
				report({$sformatf("tone %0d: expected hz=%0d ms=%0d led=%b last=%b",
					tones, want.hz, want.ms, want.led, want.last),
					$sformatf(", got hz=%0d ms=%0d led=%b last=%b",
					got.hz, got.ms, got.led, got.last)});
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              raw_level = 1'b1;
	logic              out_stall = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic              in_stall;
	logic              out_valid;
	logic [HZ_W-1:0]   tone_hz;
	logic [MS_W-1:0]   tone_ms;
	logic              led_on;
	logic              last_of_tick;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	tone_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int snd_calm     = 0;
	int hold_seq     = 0;
	int hold_len     = 0;
	int reg_writes   = 0;

	button_press_tone_sequencer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_level    (raw_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tone_hz      (tone_hz),
		.tone_ms      (tone_ms),
		.led_on       (led_on),
		.last_of_tick (last_of_tick),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		#(64'd30_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		int seen_hold;
		int calm;
		hold_left = 0;
		seen_hold = 0;
		calm = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen_hold) begin
				seen_hold = hold_seq;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm > 0) begin
				calm--;
				out_stall <= 1'b0;
			end else begin
				if ($urandom_range(0, 49) == 0)
					calm = $urandom_range(10, 40);
				out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	always @(negedge clk) begin : monitor
		tone_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.hz = tone_hz;
			got.ms = tone_ms;
			got.led = led_on;
			got.last = last_of_tick;
			sb.check_tone(got);
		end
	end

	task automatic send_tick(input logic lvl);
		logic go;
		if (snd_calm > 0) begin
			snd_calm--;
		end else begin
			if ($urandom_range(0, 49) == 0)
				snd_calm = $urandom_range(10, 40);
			while ($urandom_range(0, 99) < snd_idle_pct) begin
				in_valid <= 1'b0;
				raw_level <= 1'($urandom_range(0, 1));
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		raw_level <= lvl;
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		sb.note_tick(lvl);
	endtask

	task automatic send_run(input logic lvl, input int n);
		repeat (n) send_tick(lvl);
	endtask

	task automatic bounce(input int n);
		repeat (n) send_tick(1'($urandom_range(0, 1)));
	endtask

	// stop offering, wait for every expected tone, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.set_reg(idx, val);
		reg_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] idx);
		logic [DATA_W-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		want = sb.reg_value(idx);
		if (prdata !== want)
			sb.report($sformatf("register %0d read: expected %0d got %0d", idx, want, prdata));
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input int deb, input int lp, input int intv,
			input int f0, input int f1, input int f2, input int f3);
		drain();
		reg_write(REG_DEBOUNCE, DATA_W'(deb));
		reg_write(REG_LONG, DATA_W'(lp));
		reg_write(REG_INTERVAL, DATA_W'(intv));
		reg_write(REG_FREQ0, DATA_W'(f0));
		reg_write(REG_FREQ1, DATA_W'(f1));
		reg_write(REG_FREQ2, DATA_W'(f2));
		reg_write(REG_FREQ3, DATA_W'(f3));
		for (int i = 0; i < NREGS; i++)
			reg_read(3'(i));
	endtask

	function automatic int pick_freq();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 32767;
			2:       return 20000;
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	task automatic rand_cfg();
		int deb;
		int lp;
		int intv;
		case ($urandom_range(0, 5))
			0:       deb = 0;
			1:       deb = 1;
			default: deb = $urandom_range(0, 6);
		endcase
		case ($urandom_range(0, 7))
			0:       lp = 0;
			1:       lp = 1;
			2:       lp = 65535;
			default: lp = $urandom_range(2, 25);
		endcase
		case ($urandom_range(0, 7))
			0:       intv = 0;
			1:       intv = 1;
			2:       intv = 65535;
			default: intv = $urandom_range(5, 60);
		endcase
		apply_cfg(deb, lp, intv, pick_freq(), pick_freq(), pick_freq(), pick_freq());
	endtask

	// mostly clean presses around the long-press threshold, some noise and aborted presses
	task automatic press_pattern();
		int deb;
		int lp;
		int hold;
		int pick;
		deb = int'(sb.debounce);
		lp = int'(sb.long_press);
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			if ($urandom_range(0, 1))
				bounce($urandom_range(1, 4));
			case ($urandom_range(0, 2))
				0:       hold = $urandom_range(1, (lp < 30) ? lp + 2 : 30);
				1:       hold = lp - 2 + $urandom_range(0, 4);
				default: hold = lp + $urandom_range(0, 20);
			endcase
			if (hold > 200)
				hold = $urandom_range(1, 60);
			if (hold < 1)
				hold = 1;
			send_run(1'b0, deb + hold);
			if ($urandom_range(0, 1))
				bounce($urandom_range(1, 4));
			send_run(1'b1, deb + 1 + $urandom_range(0, 30));
		end else if (pick < 9) begin
			bounce($urandom_range(1, 8));
		end else begin
			send_run(1'b0, $urandom_range(0, deb));
			send_run(1'b1, deb + 2);
		end
	endtask

	task automatic random_phase(input int budget);
		int start;
		start = sb.ticks;
		while (sb.ticks - start < budget)
			press_pattern();
	endtask

	initial begin : main
		sb = new();
		snd_idle_pct = 28;
		rcv_idle_pct = 67;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NREGS; i++)
			reg_read(3'(i));

		// short press on reset settings
		send_run(1'b0, 60);
		send_run(1'b1, 60);
		drain();
		reg_write(REG_NONE, 32'h0000_0005);
		for (int i = 0; i < NREGS; i++)
			reg_read(3'(i));

		// directed: short, long with same-tick auto tone, bounce, long off
		apply_cfg(0, 2, 3, 0, 32767, 20000, 1);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		send_run(1'b0, 4);
		send_run(1'b1, 6);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_run(1'b0, 4);
		send_run(1'b1, 2);
		// zero long press and zero interval
		apply_cfg(0, 0, 0, 440, 660, 550, 880);
		send_run(1'b0, 2);
		send_run(1'b1, 4);
		send_run(1'b0, 2);
		send_run(1'b1, 2);

		repeat (3) begin
			rand_cfg();
			random_phase(100);
		end

		snd_idle_pct = 67;
		rcv_idle_pct = 28;
		// fill the output queue: a tone per tick while the receiver holds off
		apply_cfg(0, 1, 0, pick_freq(), pick_freq(), pick_freq(), pick_freq());
		while (!sb.auto_on) begin
			send_run(1'b0, 3);
			send_run(1'b1, 2);
		end
		hold_len = 150;
		hold_seq++;
		send_run(1'b1, 40);
		drain();
		send_run(1'b1, 10);
		send_run(1'b0, 3);
		send_run(1'b1, 2);
		repeat (3) begin
			rand_cfg();
			random_phase(100);
		end

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		apply_cfg(1, 1, 1, 20000, 32767, 0, 440);
		random_phase(100);
		rand_cfg();
		random_phase(100);
		rand_cfg();
		random_phase(100);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d expected tones never arrived", sb.pending.size()));
		$display("covered %0d ticks and %0d tones over %0d register writes,",
			sb.ticks, sb.tones, reg_writes);
		$display("with bouncing input, short and long presses, auto mode and full-queue stalls");
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ button_press_tone_sequencer_unit.f @@
src/bpts_pkg.sv
src/bpts_regs.sv
src/bpts_front.sv
src/bpts_queue.sv
src/bpts_back.sv
src/button_press_tone_sequencer_unit.sv
sim/testbench.sv
